// ----- hdl/es2c_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package es2c_pkg;

  localparam int unsigned LEAP_COUNT = 25;

  // leap-second instants, 1972-07-01 through 2012-07-01
  localparam logic [31:0] LEAP_TAB [LEAP_COUNT] = '{
    32'd78796800,   32'd94694400,   32'd126230400,  32'd157766400,  32'd189302400,
    32'd220924800,  32'd252460800,  32'd283996800,  32'd315532800,  32'd362793600,
    32'd394329600,  32'd425865600,  32'd489024000,  32'd567993600,  32'd631152000,
    32'd662688000,  32'd709948800,  32'd741484800,  32'd773020800,  32'd820454400,
    32'd867715200,  32'd915148800,  32'd1136073600, 32'd1230768000, 32'd1341100800
  };

  localparam logic [4:0] LEAP_LAST_IDX = 5'(LEAP_COUNT - 1);

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [7:0] YEAR_OFS_FIRST = 8'd70;   // 1970
  localparam logic [7:0] YEAR_OFS_2100  = 8'd200;  // century year that is not leap
  localparam logic [3:0] MONTH_DEC      = 4'd11;
  localparam logic [8:0] DAYS_YEAR      = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

  // phases of one division, counted down
  localparam logic [1:0] DIV_PH_MUL  = 2'd3;
  localparam logic [1:0] DIV_PH_BACK = 2'd2;
  localparam logic [1:0] DIV_PH_REM  = 2'd1;
  localparam logic [1:0] DIV_PH_FIX  = 2'd0;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP,
    S_SUB,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     leap_step;
    logic     leap_fin;
    logic     div_step;
    logic     div_init;
    div_sel_t div_sel;
    logic     year_step;
    logic     month_init;
    logic     month_step;
    logic     capture;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic leap_last;
    logic div_last;
    logic year_done;
    logic month_done;
  } sts_t;

  // years from 1900; 2000 is leap, 2100 is not, 1900 is out of range
  function automatic logic is_leap(input logic [7:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != YEAR_OFS_2100);
  endfunction

  function automatic logic [16:0] div_base(input div_sel_t s);
    case (s)
      DIV_DAY:  div_base = SECS_PER_DAY;
      DIV_HOUR: div_base = SECS_PER_HOUR;
      DIV_MIN:  div_base = SECS_PER_MIN;
      default:  div_base = SECS_PER_MIN;
    endcase
  endfunction

  // power-of-two factor of each divisor, taken off the dividend first
  function automatic logic [2:0] div_shift(input div_sel_t s);
    case (s)
      DIV_DAY:  div_shift = 3'd7;
      DIV_HOUR: div_shift = 3'd4;
      DIV_MIN:  div_shift = 3'd2;
      default:  div_shift = 3'd2;
    endcase
  endfunction

  // truncated reciprocal of the odd factor; the estimate is at most one low
  function automatic logic [15:0] div_magic(input div_sel_t s);
    case (s)
      DIV_DAY:  div_magic = 16'd49710;
      DIV_HOUR: div_magic = 16'd36;
      DIV_MIN:  div_magic = 16'd68;
      default:  div_magic = 16'd68;
    endcase
  endfunction

  // fraction bits of each reciprocal
  function automatic logic [4:0] div_frac(input div_sel_t s);
    case (s)
      DIV_DAY:  div_frac = 5'd25;
      DIV_HOUR: div_frac = 5'd13;
      DIV_MIN:  div_frac = 5'd10;
      default:  div_frac = 5'd10;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1:                month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default:             month_len = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- hdl/epoch_seconds_to_calendar_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 33-bit count of seconds since 1970-01-01 00:00:00 into a UTC
// calendar date and time of day, less one second for each of the 25 leap-second
// instants the count has reached. One item is in work at a time; a negative count
// returns before_epoch with every other field zero. Any other count goes through
// a leap-second scan of the table, a step that subtracts the leap seconds found,
// reciprocal division for day, hour and minute (each in phases of multiply,
// multiply back, remainder and correction), a year loop that peels one year per
// cycle and a month loop that peels one month per cycle, each loop with a closing
// step, and the load of the output register. The year loop runs Y times and the
// month loop M times, Y being the years since 1970 (0 to 136) and M the month
// index (0 to 11). The year loop dominates. The result waits in an output
// register, so the next count may enter as soon as the result is captured; while
// an earlier result is still unread, a finished item waits before capture.

module epoch_seconds_to_calendar_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [32:0] in_epoch_seconds,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_year_since_1900,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day_of_month,
  output logic [8:0]              out_day_of_year,
  output logic [4:0]              out_hour,
  output logic [5:0]              out_minute,
  output logic [5:0]              out_second,
  output logic                    out_before_epoch
);

  es2c_pkg::cmd_t cmd;
  es2c_pkg::sts_t sts;

  es2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  es2c_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_epoch_seconds    (in_epoch_seconds),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_year_since_1900 (out_year_since_1900),
    .out_month           (out_month),
    .out_day_of_month    (out_day_of_month),
    .out_day_of_year     (out_day_of_year),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_before_epoch    (out_before_epoch)
  );

endmodule

`default_nettype wire

// ----- hdl/es2c_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module es2c_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire es2c_pkg::sts_t  sts,
  output es2c_pkg::cmd_t       cmd
);

  es2c_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= es2c_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.div_sel  = es2c_pkg::DIV_DAY;
    in_ready     = 1'b0;
    case (state_r)
      es2c_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = es2c_pkg::S_LEAP;
        end
      end
      es2c_pkg::S_LEAP: begin
        if (sts.neg) begin
          state_nxt = es2c_pkg::S_DONE;
        end else begin
          cmd.leap_step = 1'b1;
          if (sts.leap_last) state_nxt = es2c_pkg::S_SUB;
        end
      end
      es2c_pkg::S_SUB: begin
        cmd.leap_fin = 1'b1;
        cmd.div_init = 1'b1;
        state_nxt    = es2c_pkg::S_DAY;
      end
      es2c_pkg::S_DAY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = es2c_pkg::DIV_DAY;
        if (sts.div_last) begin
          cmd.div_init = 1'b1;
          state_nxt    = es2c_pkg::S_HOUR;
        end
      end
      es2c_pkg::S_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = es2c_pkg::DIV_HOUR;
        if (sts.div_last) begin
          cmd.div_init = 1'b1;
          state_nxt    = es2c_pkg::S_MIN;
        end
      end
      es2c_pkg::S_MIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = es2c_pkg::DIV_MIN;
        if (sts.div_last) state_nxt = es2c_pkg::S_YEAR;
      end
      es2c_pkg::S_YEAR: begin
        if (sts.year_done) begin
          cmd.month_init = 1'b1;
          state_nxt      = es2c_pkg::S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      es2c_pkg::S_MONTH: begin
        if (sts.month_done) state_nxt = es2c_pkg::S_DONE;
        else cmd.month_step = 1'b1;
      end
      es2c_pkg::S_DONE: begin
        // output register free or emptying this cycle
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = es2c_pkg::S_IDLE;
        end
      end
      default: state_nxt = es2c_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.capture) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  a_load_starts_leap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == es2c_pkg::S_LEAP))
    else $error("accepted item did not start the leap-second scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_ready))
    else $error("result captured over one not yet transferred");

  a_capture_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid_r)
    else $error("captured result not presented");

endmodule

`default_nettype wire

// ----- hdl/es2c_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module es2c_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [32:0] in_epoch_seconds,
  input  wire es2c_pkg::cmd_t     cmd,
  output es2c_pkg::sts_t          sts,
  output logic [7:0]              out_year_since_1900,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day_of_month,
  output logic [8:0]              out_day_of_year,
  output logic [4:0]              out_hour,
  output logic [5:0]              out_minute,
  output logic [5:0]              out_second,
  output logic                    out_before_epoch
);

  logic        neg_r;
  logic [31:0] num_r, num_nxt;
  logic [4:0]  leap_idx_r;
  logic [4:0]  sub_r;
  logic [1:0]  k_r;
  logic [15:0] quo_r, quo_nxt;
  logic [40:0] prod_r;
  logic [31:0] back_r;
  logic [15:0] days_r;
  logic [7:0]  year_r;
  logic [8:0]  left_r;
  logic [3:0]  mon_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;

  logic [16:0] base;
  logic [15:0] magic;
  logic [24:0] mul_a;
  logic [15:0] quo_est;
  logic        fits;
  logic        leap_yr;
  logic [8:0]  ylen;
  logic [8:0]  mlen;
  logic        month_more;

  // reciprocal estimate, then one compare and subtract puts it right
  always_comb begin
    base    = es2c_pkg::div_base(cmd.div_sel);
    magic   = es2c_pkg::div_magic(cmd.div_sel);
    mul_a   = 25'(num_r >> es2c_pkg::div_shift(cmd.div_sel));
    quo_est = 16'(prod_r >> es2c_pkg::div_frac(cmd.div_sel));
    fits    = num_r >= {15'b0, base};
    num_nxt = fits ? (num_r - {15'b0, base}) : num_r;
    quo_nxt = fits ? (quo_r + 16'd1) : quo_r;
  end

  assign leap_yr    = es2c_pkg::is_leap(year_r);
  assign ylen       = leap_yr ? es2c_pkg::DAYS_LEAP_YEAR : es2c_pkg::DAYS_YEAR;
  assign mlen       = {4'b0, es2c_pkg::month_len(mon_r, leap_yr)};
  assign month_more = (left_r > mlen) && (mon_r != es2c_pkg::MONTH_DEC);

  assign sts.neg        = neg_r;
  assign sts.leap_last  = (leap_idx_r == es2c_pkg::LEAP_LAST_IDX);
  assign sts.div_last   = (k_r == es2c_pkg::DIV_PH_FIX);
  assign sts.year_done  = (days_r < {7'b0, ylen});
  assign sts.month_done = !month_more;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r      <= in_epoch_seconds[32];
      num_r      <= in_epoch_seconds[31:0];
      leap_idx_r <= '0;
      sub_r      <= '0;
    end
    // thresholds compared against the count before any subtraction
    if (cmd.leap_step) begin
      if (num_r >= es2c_pkg::LEAP_TAB[leap_idx_r]) sub_r <= sub_r + 5'd1;
      leap_idx_r <= leap_idx_r + 5'd1;
    end
    if (cmd.leap_fin) num_r <= num_r - 32'(sub_r);
    if (cmd.div_step) begin
      case (k_r)
        es2c_pkg::DIV_PH_MUL: prod_r <= {16'b0, mul_a} * {25'b0, magic};
        es2c_pkg::DIV_PH_BACK: begin
          quo_r  <= quo_est;
          back_r <= {16'b0, quo_est} * {15'b0, base};
        end
        es2c_pkg::DIV_PH_REM: num_r <= num_r - back_r;
        default: begin
          num_r <= num_nxt;
          quo_r <= quo_nxt;
          case (cmd.div_sel)
            es2c_pkg::DIV_DAY: begin
              days_r <= quo_nxt;
              year_r <= es2c_pkg::YEAR_OFS_FIRST;
            end
            es2c_pkg::DIV_HOUR: hour_r <= quo_nxt[4:0];
            es2c_pkg::DIV_MIN: begin
              min_r <= quo_nxt[5:0];
              sec_r <= num_nxt[5:0];
            end
            default: ;
          endcase
        end
      endcase
    end
    if (cmd.div_init) k_r <= es2c_pkg::DIV_PH_MUL;
    else if (cmd.div_step) k_r <= k_r - 2'd1;
    if (cmd.year_step) begin
      days_r <= days_r - {7'b0, ylen};
      year_r <= year_r + 8'd1;
    end
    if (cmd.month_init) begin
      left_r <= days_r[8:0] + 9'd1;
      mon_r  <= '0;
    end
    if (cmd.month_step) begin
      left_r <= left_r - mlen;
      mon_r  <= mon_r + 4'd1;
    end
    if (cmd.capture) begin
      out_before_epoch    <= neg_r;
      out_year_since_1900 <= neg_r ? '0 : year_r;
      out_month           <= neg_r ? '0 : mon_r;
      out_day_of_month    <= neg_r ? '0 : left_r[4:0];
      out_day_of_year     <= neg_r ? '0 : days_r[8:0];
      out_hour            <= neg_r ? '0 : hour_r;
      out_minute          <= neg_r ? '0 : min_r;
      out_second          <= neg_r ? '0 : sec_r;
    end
  end

  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (out_before_epoch || (out_day_of_month != 5'd0)))
    else $error("day of month zero for a non-negative count");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> ((out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60)))
    else $error("time of day out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.month_step |-> (mon_r < es2c_pkg::MONTH_DEC))
    else $error("month stepped past december");

endmodule

`default_nettype wire
